### rtl/edlr_pkg.sv
// ----------------------------------------------------------------------------
// edlr_pkg
// Shared constants, types and tap tables of the eight-direction line filter.
// ----------------------------------------------------------------------------
package edlr_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WID_W      = COL_W + 1;
	localparam int LAG_W      = WID_W + 2;
	localparam int ROW_W      = 17;
	localparam int HGT_W      = 16;
	localparam int PIX_W      = 8;
	localparam int TAPS       = 9;
	localparam int RESP_W     = 12;
	localparam int DIRS       = 8;
	localparam int WFIELD_W   = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN    = 2'd2;

	localparam int WIDTH_RST  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int HEIGHT_RST = 480;

	// centre tap index along either window axis, and the last one
	localparam logic [3:0] TAP_MID  = 4'd4;
	localparam logic [3:0] TAP_LAST = 4'd8;

	localparam int OUTER_DY [DIRS] = '{0, -2, -4, -4, -4, -4, -4, -2};
	localparam int OUTER_DX [DIRS] = '{-4, -4, -4, -2, 0, 2, 4, 4};
	localparam int INNER_DY [DIRS] = '{0, -1, -2, -2, -2, -2, -2, -1};
	localparam int INNER_DX [DIRS] = '{-2, -2, -2, -1, 0, 1, 2, 2};

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [TAPS-1:0] colvec_t;
	typedef logic signed [RESP_W-1:0] resp_t;

	typedef struct packed {
		logic             valid;
		pix_t             pixel;
		logic [COL_W-1:0] col;
		logic [3:0]       v_lo;
		logic [3:0]       v_hi;
		logic             emit;
		logic             last;
		logic [3:0]       h_lo;
		logic [3:0]       h_hi;
	} item_t;

	typedef struct packed {
		logic       valid;
		logic       emit;
		logic       last;
		logic [3:0] h_lo;
		logic [3:0] h_hi;
	} tag_t;

	typedef struct packed {
		logic valid;
		pix_t value;
		logic last;
	} result_t;

endpackage

### rtl/edlr_ram.sv
// ----------------------------------------------------------------------------
// edlr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module edlr_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/edlr_ctrl.sv
// ----------------------------------------------------------------------------
// edlr_ctrl
// Configuration registers, raster counters and the input stage register.
// ----------------------------------------------------------------------------
module edlr_ctrl import edlr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  s_tvalid,
	input  logic [PIX_W-1:0]      s_tdata,
	input  logic                  s_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  accept,
	output logic [COL_W-1:0]      rd_col,
	output item_t                 item_s1,
	output logic                  pick_min
);

	logic [WID_W-1:0] width_q;
	logic [HGT_W-1:0] height_q;
	logic             pick_q;
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [HGT_W-1:0] out_row_q;
	logic [LAG_W-1:0] cnt_q;

	logic [LAG_W-1:0]    lag_val;
	logic                emit;
	logic                last;
	logic                col_wrap;
	logic                in_done;
	logic                cfg_hit;
	logic                restart;
	logic [ROW_W-1:0]    over;
	logic [3:0]          bo;
	logic [WID_W-1:0]    rem_full;
	logic [3:0]          rem;
	logic [3:0]          cl;
	logic [WFIELD_W-1:0] wv;
	logic [WID_W-1:0]    width_d;
	logic [HGT_W-1:0]    height_d;
	item_t               item_d;

	assign accept   = en && s_tvalid;
	assign rd_col   = in_col_q;
	assign pick_min = pick_q;

	always_comb begin
		lag_val  = LAG_W'({width_q, 2'b00}) + LAG_W'(4);
		emit     = cnt_q == lag_val;
		last     = (out_row_q == height_q - HGT_W'(1))
			&& (WID_W'(out_col_q) == width_q - WID_W'(1));
		col_wrap = (WID_W'(in_col_q) + WID_W'(1)) == width_q;
		in_done  = in_row_q >= ROW_W'(height_q);
		cfg_hit  = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
			|| cfg_index == REG_MIN);
		restart  = accept && emit && last;

		// rows past the bottom edge replicate the last image row
		over = in_row_q - ROW_W'(height_q) + ROW_W'(1);
		if (!in_done) begin
			bo = 4'd0;
		end else if (over >= ROW_W'(TAP_LAST)) begin
			bo = TAP_LAST;
		end else begin
			bo = over[3:0];
		end

		rem_full = width_q - WID_W'(1) - WID_W'(out_col_q);
		rem      = (rem_full >= WID_W'(TAP_MID)) ? TAP_MID : rem_full[3:0];
		cl       = (out_col_q >= COL_W'(TAP_MID)) ? TAP_MID : out_col_q[3:0];

		item_d.valid = s_tvalid;
		item_d.pixel = (s_tuser || in_done) ? '0 : s_tdata;
		item_d.col   = in_col_q;
		item_d.v_lo  = (in_row_q >= ROW_W'(TAP_LAST)) ? 4'd0 : TAP_LAST - in_row_q[3:0];
		item_d.v_hi  = TAP_LAST - bo;
		item_d.emit  = emit;
		item_d.last  = last;
		item_d.h_lo  = TAP_MID - rem;
		item_d.h_hi  = TAP_MID + cl;

		wv = cfg_data[WFIELD_W-1:0];
		if (wv == '0) begin
			width_d = WID_W'(1);
		end else if (int'(wv) > MAX_WIDTH) begin
			width_d = WID_W'(MAX_WIDTH);
		end else begin
			width_d = WID_W'(wv);
		end
		height_d = (cfg_data[HGT_W-1:0] == '0) ? HGT_W'(1) : cfg_data[HGT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WID_W'(WIDTH_RST);
			height_q <= HGT_W'(HEIGHT_RST);
			pick_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= width_d;
				REG_HEIGHT: height_q <= height_d;
				REG_MIN:    pick_q   <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			cnt_q     <= '0;
		end else if (cfg_hit || restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			cnt_q     <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + ROW_W'(1);
			end else begin
				in_col_q <= in_col_q + COL_W'(1);
			end
			if (emit) begin
				if (WID_W'(out_col_q) + WID_W'(1) == width_q) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + HGT_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end else begin
				cnt_q <= cnt_q + LAG_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (en) begin
			item_s1 <= item_d;
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> cnt_q == '0 && in_col_q == '0 && out_row_q == '0)
		else $error("counters not cleared at frame end");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		item_s1.valid |-> item_s1.v_lo <= item_s1.v_hi && item_s1.h_lo <= TAP_MID
			&& item_s1.h_hi >= TAP_MID)
		else $error("edge clamp limits out of order");

endmodule

### rtl/edlr_column.sv
// ----------------------------------------------------------------------------
// edlr_column
// Column line buffer, vertical edge clamp and the history of column vectors.
// ----------------------------------------------------------------------------
module edlr_column import edlr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             accept,
	input  logic [COL_W-1:0] rd_col,
	input  item_t            item_s1,
	output colvec_t          hist_q [TAPS],
	output tag_t             tag_s2
);

	localparam int OLD_W = (TAPS - 1) * PIX_W;

	logic [OLD_W-1:0] rdata;
	logic [OLD_W-1:0] old;
	logic [OLD_W-1:0] wdata;
	logic             we;
	logic             byp_q;
	logic [OLD_W-1:0] byp_data_q;
	colvec_t          v;
	colvec_t          c;
	logic [3:0]       idx;

	assign we = en && item_s1.valid;

	edlr_ram #(
		.DATA_W(OLD_W),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk  (clk),
		.we   (we),
		.waddr(item_s1.col),
		.wdata(wdata),
		.re   (accept),
		.raddr(rd_col),
		.rdata(rdata)
	);

	always_comb begin
		old = byp_q ? byp_data_q : rdata;
		for (int i = 0; i < TAPS - 1; i++) begin
			v[i] = old[i*PIX_W +: PIX_W];
		end
		v[TAPS-1] = item_s1.pixel;
		for (int i = 0; i < TAPS - 1; i++) begin
			wdata[i*PIX_W +: PIX_W] = v[i+1];
		end
		// rows above the top or below the bottom repeat the edge row
		for (int i = 0; i < TAPS; i++) begin
			if (4'(i) < item_s1.v_lo) begin
				idx = item_s1.v_lo;
			end else if (4'(i) > item_s1.v_hi) begin
				idx = item_s1.v_hi;
			end else begin
				idx = 4'(i);
			end
			c[i] = v[idx];
		end
	end

	// same-column transfer back to back: take the column still being written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (accept) begin
			byp_q <= we && (item_s1.col == rd_col);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byp_data_q <= wdata;
		end
		if (we) begin
			hist_q[0] <= c;
			for (int t = 1; t < TAPS; t++) begin
				hist_q[t] <= hist_q[t-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en) begin
			tag_s2.valid <= item_s1.valid;
			tag_s2.emit  <= item_s1.emit;
			tag_s2.last  <= item_s1.last;
			tag_s2.h_lo  <= item_s1.h_lo;
			tag_s2.h_hi  <= item_s1.h_hi;
		end
	end

	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> hist_q[1] === $past(hist_q[0]))
		else $error("column history did not shift");

endmodule

### rtl/edlr_kernel.sv
// ----------------------------------------------------------------------------
// edlr_kernel
// Horizontal edge clamp, eight line responses, extreme pick and clamp.
// ----------------------------------------------------------------------------
module edlr_kernel import edlr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    pick_min,
	input  colvec_t hist_q [TAPS],
	input  tag_t    tag_s2,
	output result_t result
);

	colvec_t rsel [TAPS];
	colvec_t lsel [TAPS];
	colvec_t wcol [TAPS];
	resp_t   resp_d [DIRS];
	resp_t   resp_s3 [DIRS];
	logic    valid_s3;
	logic    emit_s3;
	logic    last_s3;
	resp_t   best;

	always_comb begin
		resp_t so;
		resp_t si;
		resp_t mid;
		// newest column at history slot zero, edge columns repeat outward
		for (int t = 0; t < TAPS; t++) begin
			rsel[t] = hist_q[t];
			lsel[t] = hist_q[t];
		end
		for (int t = 3; t >= 0; t--) begin
			if (4'(t) < tag_s2.h_lo) begin
				rsel[t] = rsel[t+1];
			end
		end
		for (int t = 5; t < TAPS; t++) begin
			if (4'(t) > tag_s2.h_hi) begin
				lsel[t] = lsel[t-1];
			end
		end
		for (int j = 0; j < TAPS; j++) begin
			wcol[j] = (j >= 4) ? rsel[TAPS-1-j] : lsel[TAPS-1-j];
		end
		for (int k = 0; k < DIRS; k++) begin
			so = resp_t'(wcol[OUTER_DX[k]+4][OUTER_DY[k]+4])
				+ resp_t'(wcol[4-OUTER_DX[k]][4-OUTER_DY[k]]);
			si = resp_t'(wcol[INNER_DX[k]+4][INNER_DY[k]+4])
				+ resp_t'(wcol[4-INNER_DX[k]][4-INNER_DY[k]]);
			mid = resp_t'(wcol[4][4]);
			resp_d[k] = so + (so <<< 1) - si - (mid <<< 2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			resp_s3 <= resp_d;
			emit_s3 <= tag_s2.emit;
			last_s3 <= tag_s2.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= tag_s2.valid;
		end
	end

	always_comb begin
		best = resp_s3[0];
		for (int k = 1; k < DIRS; k++) begin
			if (pick_min ? (resp_s3[k] < best) : (resp_s3[k] > best)) begin
				best = resp_s3[k];
			end
		end
		result.valid = valid_s3 && emit_s3;
		result.last  = last_s3;
		if (best < 0) begin
			result.value = '0;
		end else if (best > resp_t'(255)) begin
			result.value = '1;
		end else begin
			result.value = best[PIX_W-1:0];
		end
	end

endmodule

### rtl/eight_direction_line_response.sv
// ----------------------------------------------------------------------------
// eight_direction_line_response
// 9x9 eight-direction line filter over a raster pixel stream, edge replicated.
// ----------------------------------------------------------------------------
// channel  direction  tdata          tuser / tlast
// s_*      in         [7:0] pixel    tuser[0] op (1 = flush)
// m_*      out        [7:0] result   tlast frame end
// cfg_*    in         write data     index 0 width, 1 height, 2 pick minimum
//
// one pixel per clock unless the output stalls; a result passes through, in order,
// the input register with line buffer read, column history, tap sums, output register
// results start 4*width+4 transfers into a frame; flush ticks drain the tail
// reset clears counters and sets width 640, height 480, maximum mode
// a stalled output register holds the whole pipeline and drops tready
// ----------------------------------------------------------------------------
module eight_direction_line_response import edlr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel
	input  logic                  s_tuser,   // [0] op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [PIX_W-1:0]      m_tdata,   // [7:0] out_pixel
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic             en;
	logic             accept;
	logic [COL_W-1:0] rd_col;
	item_t            item_s1;
	logic             pick_min;
	colvec_t          hist_q [TAPS];
	tag_t             tag_s2;
	result_t          result;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	edlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.rd_col   (rd_col),
		.item_s1  (item_s1),
		.pick_min (pick_min)
	);

	edlr_column u_column (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.accept (accept),
		.rd_col (rd_col),
		.item_s1(item_s1),
		.hist_q (hist_q),
		.tag_s2 (tag_s2)
	);

	edlr_kernel u_kernel (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.pick_min(pick_min),
		.hist_q  (hist_q),
		.tag_s2  (tag_s2),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= result.value;
			m_tlast <= result.last;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && result.valid |=> m_tvalid && $stable(result.value))
		else $error("pending result lost during stall");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream bench for the eight-direction line filter: a directed table, random
// frames of random size and mode and extreme sizes, checked against an in-bench model.
// ----------------------------------------------------------------------------
module tb;
	import edlr_pkg::*;

	localparam int RING = 8 * MAX_WIDTH + 9;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [PIX_W-1:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [PIX_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	eight_direction_line_response dut (.*);

	always #5 clk = ~clk;

	typedef struct {
		logic [PIX_W-1:0] value;
		bit               frame_end;
	} response_t;

	typedef struct {
		bit               op;
		logic [PIX_W-1:0] px;
		bit               typed;
		logic [PIX_W-1:0] ev;
		bit               efe;
	} table_row_t;

	response_t pending_q[$];
	int errors = 0;
	int accepted = 0;

	// model state
	logic [PIX_W-1:0] ring_mem [RING];
	int unsigned cur_w = 640, cur_h = 480;
	bit cur_min = 0;
	int unsigned in_row = 0, in_col = 0, out_row = 0, out_col = 0;

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic int clampi(input int v, input int hi);
		return (v < 0) ? 0 : ((v > hi) ? hi : v);
	endfunction

	function automatic void line_predict(input bit op, input logic [PIX_W-1:0] px,
			output bit hit, output response_t res);
		int unsigned tot, lag, n, p;
		int r, c, rr, cc, s, best, k, i, j;
		int win [9][9];
		tot = cur_w * cur_h;
		lag = 4 * cur_w + 4;
		n = in_row * cur_w + in_col;
		hit = 0;
		res.value = '0;
		res.frame_end = 0;
		best = 0;
		if (n < tot) ring_mem[n % RING] = op ? 8'd0 : px;
		in_col++;
		if (in_col >= cur_w) begin
			in_col = 0;
			in_row++;
		end
		if (n < lag) return;
		r = out_row;
		c = out_col;
		for (i = 0; i < 9; i++) begin
			rr = clampi(r + i - 4, cur_h - 1);
			for (j = 0; j < 9; j++) begin
				cc = clampi(c + j - 4, cur_w - 1);
				p = rr * cur_w + cc;
				win[i][j] = ring_mem[p % RING];
			end
		end
		for (k = 0; k < DIRS; k++) begin
			s = 3 * (win[OUTER_DY[k]+4][OUTER_DX[k]+4] + win[4-OUTER_DY[k]][4-OUTER_DX[k]])
				- (win[INNER_DY[k]+4][INNER_DX[k]+4] + win[4-INNER_DY[k]][4-INNER_DX[k]])
				- 4 * win[4][4];
			if (k == 0 || (cur_min ? (s < best) : (s > best))) best = s;
		end
		best = clampi(best, 255);
		res.value = best[7:0];
		res.frame_end = (out_row == cur_h - 1) && (out_col == cur_w - 1);
		hit = 1;
		out_col++;
		if (out_col >= cur_w) begin
			out_col = 0;
			out_row++;
		end
		if (res.frame_end) begin
			in_row = 0; in_col = 0; out_row = 0; out_col = 0;
		end
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		int unsigned v;
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = d;
		@(negedge clk);
		cfg_we = 0;
		if (idx == REG_WIDTH) begin
			v = d[11:0];
			if (v == 0) v = 1;
			if (v > MAX_WIDTH) v = MAX_WIDTH;
			cur_w = v;
		end else if (idx == REG_HEIGHT) begin
			v = d;
			if (v == 0) v = 1;
			cur_h = v;
		end else begin
			cur_min = d[0];
		end
		in_row = 0; in_col = 0; out_row = 0; out_col = 0;
	endtask

	// wait for every expected result, then for the pipeline tail
	task automatic drain();
		while (pending_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic send(input bit op, input logic [PIX_W-1:0] px, input bit gaps,
			input bit typed, input response_t typed_res);
		bit hit;
		response_t res;
		int g;
		g = 0;
		if (gaps && $urandom_range(0, 1)) g = ($urandom_range(0, 9) < 8) ?
			$urandom_range(1, 3) : $urandom_range(8, 30);
		if (g > 0) begin
			@(negedge clk);
			s_tvalid = 0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1;
		s_tuser = op;
		s_tdata = px;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		accepted++;
		line_predict(op, px, hit, res);
		if (typed) pending_q.push_back(typed_res);
		else if (hit) pending_q.push_back(res);
	endtask

	task automatic idle_input();
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic run_frame(input bit gaps, input bit truncate);
		int unsigned total, stop, i;
		response_t none;
		bit op;
		none = '{default: 0};
		total = cur_w * cur_h + 4 * cur_w + 4;
		stop = truncate ? $urandom_range(1, total) : total;
		for (i = 0; i < stop; i++) begin
			if (i < cur_w * cur_h) op = ($urandom_range(0, 19) == 0);
			else op = ($urandom_range(0, 4) != 0);
			send(op, 8'($urandom_range(0, 255)), gaps, 0, none);
		end
		idle_input();
	endtask

	// output side: random stalls, plus one long hold-off
	initial begin : ready_drive
		int n;
		bit held;
		held = 0;
		forever begin
			@(negedge clk);
			if (!held && accepted > 300) begin
				held = 1;
				m_tready = 0;
				repeat (400) @(negedge clk);
			end
			m_tready = 1;
			n = $urandom_range(0, 20);
			repeat (n) @(negedge clk);
			n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
			m_tready = 0;
			repeat (n) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		response_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				report("transfer with nothing expected");
			end else begin
				e = pending_q.pop_front();
				if (m_tdata !== e.value)
					report($sformatf("pixel %0d, expected %0d", m_tdata, e.value));
				if (m_tlast !== e.frame_end)
					report($sformatf("tlast %0b, expected %0b", m_tlast, e.frame_end));
			end
		end
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : main
		table_row_t rows [18];
		response_t tr;
		int i, w, h;
		foreach (ring_mem[i]) ring_mem[i] = '0;
		for (i = 0; i < 18; i++) rows[i] = '{op: 1, px: 8'h00, typed: 0, ev: 0, efe: 0};
		rows[0] = '{op: 0, px: 8'hFF, typed: 0, ev: 0, efe: 0};
		rows[4] = '{op: 0, px: 8'hAA, typed: 0, ev: 0, efe: 0};  // pixel past frame end
		rows[8] = '{op: 1, px: 8'h00, typed: 1, ev: 0, efe: 1};
		rows[9] = '{op: 1, px: 8'h55, typed: 0, ev: 0, efe: 0};  // early flush stands for 0
		rows[17] = '{op: 1, px: 8'hFF, typed: 1, ev: 0, efe: 1};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// single-pixel frames: every tap sees one value, so the response is zero
		write_reg(REG_WIDTH, 16'd1);
		write_reg(REG_HEIGHT, 16'd1);
		write_reg(REG_MIN, 16'd0);
		for (i = 0; i < 18; i++) begin
			tr.value = rows[i].ev;
			tr.frame_end = rows[i].efe;
			send(rows[i].op, rows[i].px, 0, rows[i].typed, tr);
		end
		idle_input();
		drain();

		// random frames
		while (accepted < 1020) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			write_reg(REG_WIDTH, 16'(w));
			write_reg(REG_HEIGHT, 16'(h));
			write_reg(REG_MIN, 16'($urandom_range(0, 65535)));
			run_frame(($urandom_range(0, 3) != 0), ($urandom_range(0, 4) == 0));
			drain();
		end

		// extremes: width above the maximum clamps, frame cut short
		write_reg(REG_WIDTH, 16'h0FFF);
		write_reg(REG_HEIGHT, 16'd1);
		write_reg(REG_MIN, 16'd1);
		for (i = 0; i < 60; i++)
			send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1, 0, tr);
		idle_input();
		drain();
		// zero width, tallest frame, cut short
		write_reg(REG_WIDTH, 16'h0000);
		write_reg(REG_HEIGHT, 16'hFFFF);
		write_reg(REG_MIN, 16'hFFFE);
		for (i = 0; i < 40; i++)
			send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1, 0, tr);
		idle_input();
		drain();
		// zero height, upper width bits masked off
		write_reg(REG_HEIGHT, 16'h0000);
		write_reg(REG_WIDTH, 16'hF005);
		run_frame(1, 0);
		drain();

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
